// ===== rtl/bsfd_pkg.sv =====
// Shared constants and types for the byte-stuffed frame decoder.
// Depends on nothing; every other file of the block imports it.
package bsfd_pkg;

   // Framing and escape codes on the raw stream.
   localparam logic [7:0] MARK_END   = 8'h3c;
   localparam logic [7:0] MARK_ESC   = 8'h3d;
   localparam logic [7:0] MARK_START = 8'h3e;
   localparam logic [7:0] ESC_END    = 8'h2c;
   localparam logic [7:0] ESC_ESC    = 8'h2d;
   localparam logic [7:0] ESC_START  = 8'h2e;

   // Header is type, sequence and a four-byte length.
   localparam int HEADER_BYTES = 6;
   localparam int COUNT_W      = 33;
   localparam int DEFAULT_MIN_BODY_BYTES = 7;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Frame status codes. At frame end a bad escape is checked before an
   // escape left open, so the priority does not follow the numbering.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SHORT      = 3'd1;
   localparam logic [2:0] ST_DELIMITER  = 3'd2;
   localparam logic [2:0] ST_ESC_AT_END = 3'd3;
   localparam logic [2:0] ST_BAD_ESC    = 3'd4;
   localparam logic [2:0] ST_BODY_SHORT = 3'd5;
   localparam logic [2:0] ST_SIZE       = 3'd6;
   localparam logic [2:0] ST_CHECKSUM   = 3'd7;

   typedef struct packed {
      logic        emit;
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_type;
      logic [7:0]  sequence_number;
      logic [31:0] payload_length;
      logic [2:0]  frame_status;
   } bsfd_result_type;

endpackage

// ===== rtl/bsfd_parser.sv =====
// Frame state and per-word decode: unescaping, header capture, checksum
// and end-of-frame status. Depends on bsfd_pkg.
module bsfd_parser #(
   parameter int MIN_BODY_BYTES = bsfd_pkg::DEFAULT_MIN_BODY_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [7:0]                data_byte,
   input  logic                      frame_last,
   output bsfd_pkg::bsfd_result_type rsp_next
);
   import bsfd_pkg::*;

   logic               open_ff, open_in;
   logic               start_ok_ff, start_ok_in;
   logic               esc_pending_ff, esc_pending_in;
   logic               esc_error_ff, esc_error_in;
   logic [COUNT_W-1:0] body_count_ff, body_count_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         seq_ff, seq_in;
   logic [31:0]        length_ff, length_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         cksum_ff, cksum_in;
   logic               cksum_seen_ff, cksum_seen_in;

   logic               have_byte;
   logic [7:0]         body_byte;
   logic [COUNT_W:0]   end_pos;
   logic [COUNT_W:0]   count_ext;
   logic               in_header;
   logic [2:0]         end_status;

   assign end_pos   = (COUNT_W+1)'(HEADER_BYTES) + {2'b00, length_ff};
   assign count_ext = {1'b0, body_count_ff};
   assign in_header = body_count_ff < COUNT_W'(HEADER_BYTES);

   // Status of a frame whose final word is data_byte.
   always_comb begin
      if (!start_ok_ff || data_byte != MARK_END) begin
         end_status = ST_DELIMITER;
      end else if (esc_error_ff) begin
         end_status = ST_BAD_ESC;
      end else if (esc_pending_ff) begin
         end_status = ST_ESC_AT_END;
      end else if (body_count_ff < COUNT_W'(MIN_BODY_BYTES)) begin
         end_status = ST_BODY_SHORT;
      end else if (count_ext <= end_pos || !cksum_seen_ff) begin
         end_status = ST_SIZE;
      end else if (cksum_ff != sum_ff) begin
         end_status = ST_CHECKSUM;
      end else begin
         end_status = ST_OK;
      end
   end

   always_comb begin
      open_in        = open_ff;
      start_ok_in    = start_ok_ff;
      esc_pending_in = esc_pending_ff;
      esc_error_in   = esc_error_ff;
      body_count_in  = body_count_ff;
      type_in        = type_ff;
      seq_in         = seq_ff;
      length_in      = length_ff;
      sum_in         = sum_ff;
      cksum_in       = cksum_ff;
      cksum_seen_in  = cksum_seen_ff;
      have_byte      = 1'b0;
      body_byte      = data_byte;

      rsp_next                 = '0;
      rsp_next.frame_type      = type_ff;
      rsp_next.sequence_number = seq_ff;
      rsp_next.payload_length  = length_ff;

      if (take) begin
         if (frame_last) begin
            rsp_next.emit         = 1'b1;
            rsp_next.kind         = KIND_STATUS;
            rsp_next.frame_status = open_ff ? end_status : ST_SHORT;
            open_in        = 1'b0;
            start_ok_in    = 1'b0;
            esc_pending_in = 1'b0;
            esc_error_in   = 1'b0;
            body_count_in  = '0;
            type_in        = '0;
            seq_in         = '0;
            length_in      = '0;
            sum_in         = '0;
            cksum_in       = '0;
            cksum_seen_in  = 1'b0;
         end else if (!open_ff) begin
            open_in     = 1'b1;
            start_ok_in = (data_byte == MARK_START);
         end else if (!esc_error_ff) begin
            if (esc_pending_ff) begin
               esc_pending_in = 1'b0;
               have_byte      = 1'b1;
               case (data_byte)
                  ESC_END:   body_byte = MARK_END;
                  ESC_ESC:   body_byte = MARK_ESC;
                  ESC_START: body_byte = MARK_START;
                  default: begin
                     esc_error_in = 1'b1;
                     have_byte    = 1'b0;
                  end
               endcase
            end else if (data_byte == MARK_ESC) begin
               esc_pending_in = 1'b1;
            end else begin
               have_byte = 1'b1;
            end
         end

         if (have_byte) begin
            if (body_count_ff == COUNT_W'(0)) begin
               type_in = body_byte;
            end else if (body_count_ff == COUNT_W'(1)) begin
               seq_in = body_byte;
            end else if (in_header) begin
               length_in = {length_ff[23:0], body_byte};
            end

            if (in_header) begin
               sum_in = sum_ff + body_byte;
            end else if (count_ext < end_pos) begin
               sum_in = sum_ff + body_byte;
               if (start_ok_ff) begin
                  rsp_next.emit         = 1'b1;
                  rsp_next.kind         = KIND_PAYLOAD;
                  rsp_next.payload_byte = body_byte;
               end
            end else if (count_ext == end_pos) begin
               cksum_in      = body_byte;
               cksum_seen_in = 1'b1;
            end

            if (body_count_ff != '1) begin
               body_count_in = body_count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff        <= 1'b0;
         start_ok_ff    <= 1'b0;
         esc_pending_ff <= 1'b0;
         esc_error_ff   <= 1'b0;
         body_count_ff  <= '0;
         type_ff        <= '0;
         seq_ff         <= '0;
         length_ff      <= '0;
         sum_ff         <= '0;
         cksum_ff       <= '0;
         cksum_seen_ff  <= 1'b0;
      end else begin
         open_ff        <= open_in;
         start_ok_ff    <= start_ok_in;
         esc_pending_ff <= esc_pending_in;
         esc_error_ff   <= esc_error_in;
         body_count_ff  <= body_count_in;
         type_ff        <= type_in;
         seq_ff         <= seq_in;
         length_ff      <= length_in;
         sum_ff         <= sum_in;
         cksum_ff       <= cksum_in;
         cksum_seen_ff  <= cksum_seen_in;
      end
   end

endmodule

// ===== rtl/byte_stuffed_frame_decoder_core.sv =====
// Byte-stuffed frame decoder: raw words in, payload words and one closing
// status word out. An accepted word's result is in the output register in
// the next cycle; throughput is one word per cycle while req_ready is high.
// Synchronous active-high reset clears the frame state and the output valid.
// Depends on bsfd_pkg and bsfd_parser.
module byte_stuffed_frame_decoder_core #(
   parameter int MIN_BODY_BYTES = bsfd_pkg::DEFAULT_MIN_BODY_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_sequence_number,
   output logic [31:0] rsp_payload_length,
   output logic [2:0]  rsp_frame_status,
   output logic        rsp_frame_done
);
   import bsfd_pkg::*;

   // The parser updates its frame state on every accepted word and offers
   // at most one result word in the same cycle. That word is captured in
   // the output register. A new word is taken whenever the output register
   // is empty or is being drained this cycle, so a waiting result never
   // stalls the input unless the consumer is also stalling.
   logic            take;
   bsfd_result_type rsp_next;
   bsfd_result_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   bsfd_parser #(
      .MIN_BODY_BYTES (MIN_BODY_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .frame_last (req_frame_last),
      .rsp_next   (rsp_next)
   );

   // Output valid: loaded by a word that yields a result, dropped when the
   // held result is taken and nothing replaces it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && rsp_next.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the output register needs no reset.
   always_ff @(posedge clock) begin
      if (take && rsp_next.emit) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_ff.kind;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_frame_type      = rsp_ff.frame_type;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_payload_length  = rsp_ff.payload_length;
   assign rsp_frame_status    = rsp_ff.frame_status;
   assign rsp_frame_done      = rsp_ff.kind == KIND_STATUS;

endmodule
